// ===== hdl/ert_pkg.sv =====
// Package with the item types, constants and helper functions of the tile region calculator.
package ert_pkg;

  localparam int unsigned STORE_TILES = 2048;
  localparam int unsigned TILE_TEXELS_WIDE = 80;
  localparam int unsigned HEIGHT_CAP = 2560;
  localparam int unsigned QUO_BITS = 12;

  typedef struct packed {
    logic        fmt_wide;
    logic [1:0]  msaa_level;
    logic [11:0] base_offset_tiles;
    logic [12:0] row_stride;
    logic [12:0] rect_x;
    logic [12:0] rect_y;
    logic [12:0] rect_width;
    logic [12:0] rect_height;
  } req_t;

  typedef struct packed {
    logic        region_ok;
    logic [14:0] adj_x;
    logic [14:0] adj_y;
    logic [14:0] adj_width;
    logic [14:0] adj_height;
    logic [10:0] add_offset_tiles;
    logic [9:0]  extent_width_tiles;
    logic [11:0] extent_height_tiles;
    logic [9:0]  stride_tiles;
    logic [11:0] max_height_px;
  } rsp_t;

  // Region description that travels down the divider chain.
  typedef struct packed {
    logic        bad;
    logic        clamp;
    logic        fmt64;
    logic        hp;
    logic [9:0]  top;
    logic [8:0]  left;
    logic [9:0]  wtiles;
    logic [11:0] htiles;
    logic [9:0]  ptiles;
    logic [10:0] add;
  } job_t;

  // One restoring division in flight.
  typedef struct packed {
    logic [9:0]  rem;
    logic [11:0] num;
    logic [11:0] quo;
  } lane_t;

  typedef struct packed {
    job_t  job;
    lane_t a;
    lane_t b;
  } cell_t;

  // Divide by the tile width of 80 texels: a shift by four bits, then a reciprocal of 5.
  function automatic logic [9:0] div80(input logic [16:0] v);
    logic [31:0] p;
    p = {19'd0, v[16:4]} * 32'd52429;
    return p[27:18];
  endfunction

endpackage

// ===== hdl/ert_stream_if.sv =====
// Valid/ready stream interface that carries one item per handshake.
interface ert_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== hdl/edram_tile_region_calc_unit.sv =====
// Top level of the EDRAM tile region calculator.
// The unit takes one request item per cycle unless the pipeline stalls, and returns one
// result item per request, in order. Three front stages scale the rectangle, snap it to
// tiles and form the tile offset and the area products; a chain of 12 divider cells
// then produces one quotient bit per cell for the clamped height and the height limit,
// and an output register holds the result.
// Every stage stalls only when the stage after it is full and held.
module edram_tile_region_calc_unit (
  input logic clk,
  input logic rst,
  ert_stream_if.sink   req,
  ert_stream_if.source rsp
);
  import ert_pkg::*;

  // Stage valids and the ready chain.
  logic v1, v2, v3, ov;
  logic r1, r2, r3, ro;
  logic [QUO_BITS-1:0] cv;
  logic [QUO_BITS-1:0] crdy;
  cell_t cd [QUO_BITS];
  cell_t c_in;

  always_comb begin
    ro = !ov || rsp.ready;
    crdy[QUO_BITS-1] = !cv[QUO_BITS-1] || ro;
    for (int i = QUO_BITS - 2; i >= 0; i--) begin
      crdy[i] = !cv[i] || crdy[i+1];
    end
    r3 = !v3 || crdy[0];
    r2 = !v2 || r3;
    r1 = !v1 || r2;
  end

  assign req.ready = r1;
  assign rsp.valid = ov;

  // Stage 1: the accepted request item.
  req_t s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (r1) begin
      v1 <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      s1 <= req.data;
    end
  end

  // Scale to texels and snap outward to whole tiles.
  logic        bad_c;
  logic        hp_c;
  logic [1:0]  wp_c;
  logic [14:0] xs_c, ws_c, ps_c, ys_c, hs_c;
  logic [9:0]  left_c, right_c, pt_c, wt_c, top_c;
  logic [11:0] bottom_c;

  always_comb begin
    bad_c = (s1.base_offset_tiles >= 12'(STORE_TILES)) || (s1.row_stride == 13'd0) ||
            (s1.rect_width == 13'd0) || (s1.rect_height == 13'd0) ||
            (s1.rect_x >= s1.row_stride);
    hp_c = (s1.msaa_level != 2'd0);
    wp_c = {1'b0, s1.fmt_wide} + {1'b0, s1.msaa_level >= 2'd2};
    xs_c = {2'b0, s1.rect_x} << wp_c;
    ws_c = {2'b0, s1.rect_width} << wp_c;
    ps_c = {2'b0, s1.row_stride} << wp_c;
    ys_c = {2'b0, s1.rect_y} << hp_c;
    hs_c = {2'b0, s1.rect_height} << hp_c;
    left_c = div80({2'b0, xs_c});
    right_c = div80({2'b0, xs_c} + {2'b0, ws_c} + 17'(TILE_TEXELS_WIDE - 1));
    pt_c = div80({2'b0, ps_c} + 17'(TILE_TEXELS_WIDE - 1));
    top_c = ys_c[13:4];
    bottom_c = 12'(({1'b0, ys_c} + {1'b0, hs_c} + 16'd15) >> 4);
    wt_c = right_c - left_c;
    if (wt_c > pt_c) begin
      wt_c = pt_c;
    end
  end

  // Stage 2: tile coordinates.
  logic        bad2, fmt2, hp2;
  logic [11:0] base2;
  logic [9:0]  top2, wt2, pt2;
  logic [8:0]  left2;
  logic [11:0] ht2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (r2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (r2) begin
      bad2 <= bad_c;
      fmt2 <= s1.fmt_wide;
      hp2 <= hp_c;
      base2 <= s1.base_offset_tiles;
      top2 <= top_c;
      left2 <= left_c[8:0];
      wt2 <= wt_c;
      pt2 <= pt_c;
      ht2 <= bottom_c - {2'b0, top_c};
    end
  end

  // Stage 3: offset of the region start and the area in tiles.
  logic        bad3, fmt3, hp3;
  logic [11:0] base3;
  logic [9:0]  top3, wt3, pt3;
  logic [8:0]  left3;
  logic [11:0] ht3;
  logic [19:0] add3, prod3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (r3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (r3) begin
      bad3 <= bad2;
      fmt3 <= fmt2;
      hp3 <= hp2;
      base3 <= base2;
      top3 <= top2;
      left3 <= left2;
      wt3 <= wt2;
      pt3 <= pt2;
      ht3 <= ht2;
      add3 <= 20'({10'd0, top2} * {10'd0, pt2}) + {11'd0, left2};
      prod3 <= 20'({8'd0, ht2} * {10'd0, pt2});
    end
  end

  // Check the region against the store end and load the divider chain.
  logic [20:0] start_c;

  always_comb begin
    start_c = {9'd0, base3} + {1'b0, add3};
    c_in.job.bad = bad3 || (start_c >= 21'(STORE_TILES));
    c_in.job.clamp = (start_c + {1'b0, prod3}) > 21'(STORE_TILES);
    c_in.job.fmt64 = fmt3;
    c_in.job.hp = hp3;
    c_in.job.top = top3;
    c_in.job.left = left3;
    c_in.job.wtiles = wt3;
    c_in.job.htiles = ht3;
    c_in.job.ptiles = pt3;
    c_in.job.add = add3[10:0];
    c_in.a.rem = 10'd0;
    c_in.a.num = 12'(STORE_TILES) - start_c[11:0];
    c_in.a.quo = 12'd0;
    c_in.b.rem = 10'd0;
    c_in.b.num = 12'(STORE_TILES) - base3;
    c_in.b.quo = 12'd0;
  end

  // Divider chain, one quotient bit per cell.
  for (genvar g = 0; g < QUO_BITS; g++) begin : g_cell
    if (g == 0) begin : g_first
      ert_div_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .en   (crdy[g]),
        .in_v (v3),
        .in_d (c_in),
        .out_v(cv[g]),
        .out_d(cd[g])
      );
    end else begin : g_next
      ert_div_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .en   (crdy[g]),
        .in_v (cv[g-1]),
        .in_d (cd[g-1]),
        .out_v(cv[g]),
        .out_d(cd[g])
      );
    end
  end

  // Assemble the result item from the finished quotients.
  job_t        fj;
  logic [11:0] qa, qb, ht_f;
  logic        ok_f;
  logic [15:0] ax_f, aw_f, ah_f, mh_f;
  rsp_t        res;

  always_comb begin
    fj = cd[QUO_BITS-1].job;
    qa = cd[QUO_BITS-1].a.quo;
    qb = cd[QUO_BITS-1].b.quo;
    ht_f = fj.clamp ? qa : fj.htiles;
    ok_f = !fj.bad && !(fj.clamp && (qa == 12'd0));
    ax_f = ({7'd0, fj.left} << 6) + ({7'd0, fj.left} << 4);
    aw_f = ({6'd0, fj.wtiles} << 6) + ({6'd0, fj.wtiles} << 4);
    if (fj.fmt64) begin
      ax_f = ax_f >> 1;
      aw_f = aw_f >> 1;
    end
    ah_f = {ht_f, 4'd0};
    mh_f = fj.hp ? {1'b0, qb, 3'd0} : {qb, 4'd0};
    if (mh_f > 16'(HEIGHT_CAP)) begin
      mh_f = 16'(HEIGHT_CAP);
    end
    res = '0;
    if (ok_f) begin
      res.region_ok = 1'b1;
      res.adj_x = ax_f[14:0];
      res.adj_y = {1'b0, fj.top, 4'd0};
      res.adj_width = aw_f[14:0];
      res.adj_height = ah_f[14:0];
      res.add_offset_tiles = fj.add;
      res.extent_width_tiles = fj.wtiles;
      res.extent_height_tiles = ht_f;
      res.stride_tiles = fj.ptiles;
      res.max_height_px = mh_f[11:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (ro) begin
      ov <= cv[QUO_BITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ro) begin
      rsp.data <= res;
    end
  end
endmodule

// ===== hdl/ert_div_cell.sv =====
// One cell of the divider chain: a quotient bit for both divisions per cycle while enabled.
module ert_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_v,
  input  ert_pkg::cell_t in_d,
  output logic          out_v,
  output ert_pkg::cell_t out_d
);
  import ert_pkg::*;

  cell_t step;

  function automatic lane_t lane_step(input lane_t l, input logic [9:0] d);
    logic [10:0] t;
    logic [10:0] dd;
    lane_t r;
    t = {l.rem, l.num[11]};
    dd = {1'b0, d};
    r.num = {l.num[10:0], 1'b0};
    if (t >= dd) begin
      r.rem = 10'(t - dd);
      r.quo = {l.quo[10:0], 1'b1};
    end else begin
      r.rem = t[9:0];
      r.quo = {l.quo[10:0], 1'b0};
    end
    return r;
  endfunction

  // Shift one numerator bit into each remainder and subtract where it fits.
  always_comb begin
    step.job = in_d.job;
    step.a = lane_step(in_d.a, in_d.job.ptiles);
    step.b = lane_step(in_d.b, in_d.job.ptiles);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d <= step;
    end
  end
endmodule
